// File: rtl/sbcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_pkg
// shared types and constants of the servo bus command framer
// ----------------------------------------------------------------------------
package sbcf_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] LEN_BASE_NO_ADDR = 8'd2;
   localparam logic [7:0] LEN_BASE_ADDR = 8'd3;

   // item kinds on req_tuser
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_PARAM  = 1'b1;

   // one unit of work for the back end
   typedef struct packed {
      logic       is_header;
      logic       close;       // checksum follows this unit
      logic [7:0] data_byte;   // node id on headers, parameter byte otherwise
      logic [7:0] instruction;
      logic       has_address;
      logic [7:0] address;
      logic [7:0] len_byte;
   } sbcf_job_type;

   typedef struct packed {
      logic         valid;
      sbcf_job_type job;
   } sbcf_slot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SYNC1,
      ST_SYNC2,
      ST_ID,
      ST_LEN,
      ST_INSTR,
      ST_ADDR,
      ST_PARAM,
      ST_CSUM
   } sbcf_step_type;

endpackage

// File: rtl/sbcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_front
// accepts items, tracks the open frame and queues work for the back end
// ----------------------------------------------------------------------------
module sbcf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   input  logic [7:0]             node_id,
   input  logic [7:0]             instruction,
   input  logic                   has_address,
   input  logic [7:0]             register_address,
   input  logic [7:0]             param_count,
   input  logic [7:0]             param_byte,
   input  logic                   queue_full,
   output sbcf_pkg::sbcf_slot_type push
);

   logic       fire;
   logic [7:0] params_left_ff, params_left_in;
   logic       open_ff, open_in;

   assign req_tready = !queue_full;
   assign fire = req_tvalid && req_tready;

   always_comb begin
      params_left_in = params_left_ff;
      open_in = open_ff;
      push.valid = 1'b0;
      push.job.is_header = 1'b0;
      push.job.close = 1'b0;
      push.job.data_byte = param_byte;
      push.job.instruction = instruction;
      push.job.has_address = has_address;
      push.job.address = register_address;
      push.job.len_byte = param_count + (has_address ? sbcf_pkg::LEN_BASE_ADDR
                                                     : sbcf_pkg::LEN_BASE_NO_ADDR);
      if (fire) begin
         if (req_tuser == sbcf_pkg::CMD_HEADER) begin
            push.valid = 1'b1;
            push.job.is_header = 1'b1;
            push.job.data_byte = node_id;
            push.job.close = (param_count == 8'd0);
            params_left_in = param_count;
            open_in = (param_count != 8'd0);
         end else if (open_ff && params_left_ff != 8'd0) begin
            // parameters outside an open frame are dropped here
            push.valid = 1'b1;
            push.job.close = (params_left_ff == 8'd1);
            params_left_in = params_left_ff - 8'd1;
            open_in = (params_left_ff != 8'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         params_left_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         params_left_ff <= params_left_in;
         open_ff <= open_in;
      end
   end

   // a parameter unit is only queued while a frame waits for it
   assert property (@(posedge clock) disable iff (reset)
      push.valid && !push.job.is_header |-> open_ff && params_left_ff != 8'd0)
      else $error("parameter queued outside an open frame");

   // the open flag and the remaining count agree
   assert property (@(posedge clock) disable iff (reset)
      open_ff == (params_left_ff != 8'd0))
      else $error("frame open flag out of step with parameter count");

endmodule

// File: rtl/sbcf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_queue
// short show-ahead queue of work units between front and back end
// ----------------------------------------------------------------------------
module sbcf_queue #(
   parameter int DEPTH = sbcf_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sbcf_pkg::sbcf_slot_type push,
   output logic                    full,
   output sbcf_pkg::sbcf_slot_type head,
   input  logic                    pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sbcf_pkg::sbcf_job_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job = entries_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.job;
      end
   end

   // occupancy never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

endmodule

// File: rtl/sbcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_back
// walks queued units byte by byte, keeps the checksum and frame byte count
// ----------------------------------------------------------------------------
module sbcf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sbcf_pkg::sbcf_slot_type head,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic                    rsp_tlast,
   output logic [7:0]              frame_byte,
   output logic [8:0]              frame_length
);

   sbcf_pkg::sbcf_step_type step_ff, step_in, cur_step;
   logic       advance;
   logic       emit;
   logic [7:0] sum_ff, sum_in;
   logic [8:0] sent_ff, sent_in;
   logic [7:0] out_byte;
   logic       out_end;
   logic [8:0] out_len;
   logic       counted;
   logic [7:0] checksum;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic [8:0] len_ff;

   assign advance = !valid_ff || rsp_tready;
   assign emit = advance && head.valid;

   // step being worked this cycle
   always_comb begin
      if (step_ff == sbcf_pkg::ST_IDLE) begin
         cur_step = head.job.is_header ? sbcf_pkg::ST_SYNC1 : sbcf_pkg::ST_PARAM;
      end else begin
         cur_step = step_ff;
      end
   end

   // next state
   always_comb begin
      step_in = step_ff;
      pop = 1'b0;
      if (emit) begin
         unique case (cur_step)
            sbcf_pkg::ST_SYNC1: step_in = sbcf_pkg::ST_SYNC2;
            sbcf_pkg::ST_SYNC2: step_in = sbcf_pkg::ST_ID;
            sbcf_pkg::ST_ID:    step_in = sbcf_pkg::ST_LEN;
            sbcf_pkg::ST_LEN:   step_in = sbcf_pkg::ST_INSTR;
            sbcf_pkg::ST_INSTR: begin
               if (head.job.has_address) begin
                  step_in = sbcf_pkg::ST_ADDR;
               end else if (head.job.close) begin
                  step_in = sbcf_pkg::ST_CSUM;
               end else begin
                  step_in = sbcf_pkg::ST_IDLE;
                  pop = 1'b1;
               end
            end
            sbcf_pkg::ST_ADDR, sbcf_pkg::ST_PARAM: begin
               if (head.job.close) begin
                  step_in = sbcf_pkg::ST_CSUM;
               end else begin
                  step_in = sbcf_pkg::ST_IDLE;
                  pop = 1'b1;
               end
            end
            sbcf_pkg::ST_CSUM: begin
               step_in = sbcf_pkg::ST_IDLE;
               pop = 1'b1;
            end
            default: step_in = sbcf_pkg::ST_IDLE;
         endcase
      end
   end

   // a sum of zero inverts to 0xFF, which the bus replaces by zero
   assign checksum = (sum_ff == 8'd0) ? 8'd0 : ~sum_ff;

   // outputs of the current step
   always_comb begin
      out_byte = sbcf_pkg::SYNC_BYTE;
      out_end = 1'b0;
      out_len = '0;
      counted = 1'b0;
      unique case (cur_step)
         sbcf_pkg::ST_SYNC1, sbcf_pkg::ST_SYNC2: out_byte = sbcf_pkg::SYNC_BYTE;
         sbcf_pkg::ST_ID: begin
            out_byte = head.job.data_byte;
            counted = 1'b1;
         end
         sbcf_pkg::ST_LEN: begin
            out_byte = head.job.len_byte;
            counted = 1'b1;
         end
         sbcf_pkg::ST_INSTR: begin
            out_byte = head.job.instruction;
            counted = 1'b1;
         end
         sbcf_pkg::ST_ADDR: begin
            out_byte = head.job.address;
            counted = 1'b1;
         end
         sbcf_pkg::ST_PARAM: begin
            out_byte = head.job.data_byte;
            counted = 1'b1;
         end
         sbcf_pkg::ST_CSUM: begin
            out_byte = checksum;
            out_end = 1'b1;
            out_len = sent_ff + 9'd1;
         end
         default: out_byte = sbcf_pkg::SYNC_BYTE;
      endcase
   end

   always_comb begin
      sum_in = sum_ff;
      sent_in = sent_ff;
      if (emit) begin
         if (cur_step == sbcf_pkg::ST_SYNC1) begin
            sum_in = '0;
            sent_in = 9'd1;
         end else if (cur_step == sbcf_pkg::ST_CSUM) begin
            sum_in = '0;
            sent_in = '0;
         end else begin
            sent_in = sent_ff + 9'd1;
            if (counted) begin
               sum_in = sum_ff + out_byte;
            end
         end
      end
   end

   assign valid_in = advance ? head.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= sbcf_pkg::ST_IDLE;
         sum_ff <= '0;
         sent_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         sum_ff <= sum_in;
         sent_ff <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= out_byte;
         end_ff <= out_end;
         len_ff <= out_len;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast = end_ff;
   assign frame_byte = byte_ff;
   assign frame_length = len_ff;

   // the shortest frame has six bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> frame_length >= 9'd6)
      else $error("frame ended shorter than a bare header");

   // the address step only runs for headers that carry one
   assert property (@(posedge clock) disable iff (reset)
      step_ff == sbcf_pkg::ST_ADDR |-> head.valid && head.job.is_header
                                       && head.job.has_address)
      else $error("address step without an address");

endmodule

// File: rtl/servo_bus_command_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_command_framer_unit
// builds servo bus instruction frames as a byte stream
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  req_     | in  | req_tvalid/tready    | tuser = command, tdata = header/param fields
//  rsp_     | out | rsp_tvalid/tready    | tdata = byte + length, tlast = frame end
//
//  a parameter item yields one output byte, two when it closes the frame
//  a header yields five output bytes, six with an address, plus one for the
//  checksum when the count is zero; the byte-serial back end sends them in turn
//  items enter one per cycle while the front queue has room (QUEUE_DEPTH units)
//  reset clears the frame tracking, queue pointers and output valid at once
//  either side may stall freely; the output register holds a byte until taken
// ----------------------------------------------------------------------------
module servo_bus_command_framer_unit #(
   parameter int QUEUE_DEPTH = sbcf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // command: 0 header, 1 parameter byte
   input  logic [47:0] req_tdata,   // node_id[7:0], instruction[15:8],
                                    // has_address[16], register_address[24:17],
                                    // param_count[32:25], param_byte[40:33], zero pad
   // frame byte output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,   // frame_end
   output logic [23:0] rsp_tdata    // frame_byte[7:0], frame_length[16:8], zero pad
);

   sbcf_pkg::sbcf_slot_type push;   // front to queue
   sbcf_pkg::sbcf_slot_type head;   // queue to back end
   logic       queue_full;
   logic       pop;
   logic [7:0] frame_byte;
   logic [8:0] frame_length;

   // front: classifies items and drops parameters with no open frame
   sbcf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tuser        (req_tuser),
      .node_id          (req_tdata[7:0]),
      .instruction      (req_tdata[15:8]),
      .has_address      (req_tdata[16]),
      .register_address (req_tdata[24:17]),
      .param_count      (req_tdata[32:25]),
      .param_byte       (req_tdata[40:33]),
      .queue_full       (queue_full),
      .push             (push)
   );

   // decoupling queue
   sbcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // back end: byte sequencer with checksum and output register
   sbcf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tlast    (rsp_tlast),
      .frame_byte   (frame_byte),
      .frame_length (frame_length)
   );

   assign rsp_tdata = {7'd0, frame_length, frame_byte};

endmodule

// File: dv/sbcf_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_frame_checker
// watches both channels of the command framer, builds the byte stream each
// accepted item should produce and compares every frame byte as it is taken
// ----------------------------------------------------------------------------
module sbcf_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        rsp_tlast,
   input  logic [23:0] rsp_tdata,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
      logic [8:0] frame_length;
   } frame_out_type;

   frame_out_type frame_bytes_due[$];
   frame_out_type oldest;

   // mirror of the framer state
   logic [7:0] sum_acc;
   logic [7:0] params_due;
   logic       frame_active;
   logic [8:0] byte_count;

   task automatic report(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic emit_byte(input logic [7:0] b, input logic summed);
      frame_bytes_due.push_back(frame_out_type'{b, 1'b0, 9'd0});
      if (summed)
         sum_acc = sum_acc + b;
      byte_count = byte_count + 9'd1;
   endtask

   task automatic emit_checksum();
      logic [7:0] cs;
      cs = ~sum_acc;
      if (cs == 8'hFF)
         cs = 8'h00;
      byte_count = byte_count + 9'd1;
      frame_bytes_due.push_back(frame_out_type'{cs, 1'b1, byte_count});
      frame_active = 1'b0;
      params_due   = '0;
      sum_acc      = '0;
      byte_count   = '0;
   endtask

   task automatic predict_frame_bytes(input logic cmd, input logic [47:0] fields);
      logic [7:0] node;
      logic [7:0] instr;
      logic       has_addr;
      logic [7:0] addr;
      logic [7:0] count;
      logic [7:0] pbyte;
      logic [7:0] len_byte;
      node     = fields[7:0];
      instr    = fields[15:8];
      has_addr = fields[16];
      addr     = fields[24:17];
      count    = fields[32:25];
      pbyte    = fields[40:33];
      if (cmd == sbcf_pkg::CMD_HEADER) begin
         // a header always restarts, an open frame is simply dropped
         sum_acc    = '0;
         byte_count = '0;
         len_byte   = count + (has_addr ? sbcf_pkg::LEN_BASE_ADDR
                                        : sbcf_pkg::LEN_BASE_NO_ADDR);
         emit_byte(sbcf_pkg::SYNC_BYTE, 1'b0);
         emit_byte(sbcf_pkg::SYNC_BYTE, 1'b0);
         emit_byte(node, 1'b1);
         emit_byte(len_byte, 1'b1);
         emit_byte(instr, 1'b1);
         if (has_addr)
            emit_byte(addr, 1'b1);
         params_due   = count;
         frame_active = 1'b1;
         if (count == 8'd0)
            emit_checksum();
      end else if (frame_active && params_due != 8'd0) begin
         emit_byte(pbyte, 1'b1);
         params_due = params_due - 8'd1;
         if (params_due == 8'd0)
            emit_checksum();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_bytes_due.delete();
         sum_acc      = '0;
         params_due   = '0;
         frame_active = 1'b0;
         byte_count   = '0;
      end else begin
         // output side first: a byte taken now belongs to an earlier item
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_due.size() == 0) begin
               report("unexpected frame byte", int'(rsp_tdata[7:0]), 0);
            end else begin
               oldest = frame_bytes_due.pop_front();
               if (rsp_tdata[7:0] != oldest.frame_byte)
                  report("frame_byte", int'(rsp_tdata[7:0]), int'(oldest.frame_byte));
               if (rsp_tlast != oldest.frame_end)
                  report("frame_end", int'(rsp_tlast), int'(oldest.frame_end));
               if (rsp_tdata[16:8] != oldest.frame_length)
                  report("frame_length", int'(rsp_tdata[16:8]),
                         int'(oldest.frame_length));
               if (rsp_tdata[23:17] != '0)
                  report("tdata pad", int'(rsp_tdata[23:17]), 0);
            end
         end
         if (req_tvalid && req_tready)
            predict_frame_bytes(req_tuser, req_tdata);
      end
      outstanding <= frame_bytes_due.size();
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the servo bus command framer: a directed set of
// frames (extremes, address and no address, zero count, checksum fold,
// length wrap, abandoned frames, stray parameter bytes) then random frames
// sent in bursts against a stalling receiver; a separate checker predicts
// and compares every frame byte
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_ITEMS = 210;   // frame items to reach before stopping

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = sbcf_pkg::CMD_HEADER;   // command
   logic [47:0] req_tdata  = '0;   // node_id, instruction, has_address,
                                   // register_address, param_count, param_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tlast;        // frame_end
   logic [23:0] rsp_tdata;        // frame_byte, frame_length

   int          fail_count;
   int          outstanding;

   // sender burst bookkeeping
   int unsigned burst_left = 0;
   int unsigned frame_items = 0;   // items that do real work, stray ones excluded
   bit          frame_closed = 1'b1;

   // receiver stall pattern
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   int unsigned stall_phase = 0;

   always #4 clock = ~clock;

   servo_bus_command_framer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

   sbcf_frame_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // receiver: every so often pick a new stall style and hold it a while
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode  <= $urandom_range(0, 4);
         stall_left  <= 30 + $urandom_range(0, 70);
      end else begin
         stall_left  <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;                            // no backpressure
         1: rsp_tready <= 1'($urandom_range(0, 1));        // coin flip
         2: rsp_tready <= (stall_phase % 4 == 3);          // one cycle in four
         3: rsp_tready <= ($urandom_range(0, 7) != 0);     // rare stalls
         default: rsp_tready <= (stall_phase % 7 < 2);     // long stalls
      endcase
   end

   function automatic logic [47:0] pack_fields(input logic [7:0] node,
                                              input logic [7:0] instr,
                                              input logic       has_addr,
                                              input logic [7:0] addr,
                                              input logic [7:0] count,
                                              input logic [7:0] pbyte);
      return {7'd0, pbyte, count, addr, has_addr, instr, node};
   endfunction

   // one item, held until taken; gaps only open between bursts
   task automatic send_item(input logic cmd, input logic [47:0] fields);
      int unsigned idle;
      if (burst_left == 0) begin
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (idle > 0) begin
            req_tvalid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= fields;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // unused fields of the item kind get random values
   task automatic send_header(input logic [7:0] node, input logic [7:0] instr,
                              input logic has_addr, input logic [7:0] addr,
                              input logic [7:0] count);
      send_item(sbcf_pkg::CMD_HEADER, pack_fields(node, instr, has_addr, addr, count,
                                                  8'($urandom)));
      frame_items++;
      frame_closed = (count == 8'd0);
   endtask

   task automatic send_param(input logic [7:0] pbyte, input bit counts);
      send_item(sbcf_pkg::CMD_PARAM, pack_fields(8'($urandom), 8'($urandom),
                                                 1'($urandom), 8'($urandom),
                                                 8'($urandom), pbyte));
      if (counts)
         frame_items++;
   endtask

   // well formed frame with random content and a mostly small count
   task automatic random_frame();
      int unsigned pick;
      int unsigned count;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         count = $urandom_range(0, 4);
      else if (pick < 95)
         count = $urandom_range(5, 12);
      else
         count = $urandom_range(13, 40);
      send_header(8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom), 8'(count));
      repeat (count) send_param(8'($urandom), 1'b1);
      frame_closed = 1'b1;
   endtask

   // header whose count is never met, the next header drops it
   task automatic broken_frame();
      int unsigned count;
      int unsigned sent;
      count = $urandom_range(1, 255);
      sent  = $urandom_range(0, (count - 1 < 4) ? count - 1 : 4);
      send_header(8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom), 8'(count));
      repeat (sent) send_param(8'($urandom), 1'b1);
   endtask

   initial begin
      int unsigned pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // stray parameter byte straight after reset, nothing may come out
      send_param(8'h5A, 1'b0);
      // all-zero header, count zero: checksum right behind the header
      send_header(8'h00, 8'h00, 1'b0, 8'h00, 8'd0);
      // all-ones header with address: the longest burst from one item
      send_header(8'hFF, 8'hFF, 1'b1, 8'hFF, 8'd0);
      // byte sum folds to zero, so the inverted sum becomes zero too
      send_header(8'h00, 8'hFE, 1'b0, 8'h00, 8'd0);
      // ordinary write frame with address and two parameter extremes
      send_header(8'h01, 8'h03, 1'b1, 8'h1E, 8'd2);
      send_param(8'h00, 1'b1);
      send_param(8'hFF, 1'b1);
      // parameter after the frame closed is dropped
      send_param(8'h77, 1'b0);
      // frame abandoned by a new header halfway through
      send_header(8'h0A, 8'h02, 1'b1, 8'h24, 8'd3);
      send_param(8'h11, 1'b1);
      send_header(8'hFE, 8'h83, 1'b1, 8'h80, 8'd1);
      send_param(8'hAA, 1'b1);
      // length byte wraps past 255 for large counts
      send_header(8'h07, 8'h03, 1'b1, 8'h00, 8'd253);
      send_param(8'h01, 1'b1);
      send_param(8'h02, 1'b1);
      send_header(8'h08, 8'h03, 1'b0, 8'h00, 8'd255);
      send_param(8'h03, 1'b1);
      send_header(8'h09, 8'h04, 1'b0, 8'h00, 8'd254);
      send_header(8'h05, 8'h01, 1'b0, 8'h00, 8'd1);
      send_param(8'h55, 1'b1);

      // hold off until the framer has drained everything
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);

      // random part: mostly whole frames, some broken ones and stray bytes
      while (frame_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            random_frame();
         end else if (pick < 90) begin
            broken_frame();
         end else if (frame_closed) begin
            send_param(8'($urandom), 1'b0);
         end
      end
      // close whatever frame a broken sequence may have left open
      random_frame();

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("servo_bus_command_framer_unit test passed");
      else
         $display("servo_bus_command_framer_unit test failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("servo_bus_command_framer_unit test failed");
      $finish;
   end

endmodule

// File: files.f
rtl/sbcf_pkg.sv
rtl/sbcf_front.sv
rtl/sbcf_queue.sv
rtl/sbcf_back.sv
rtl/servo_bus_command_framer_unit.sv
dv/sbcf_frame_checker.sv
dv/tb.sv
